// ----- design/assert_macros.svh -----
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ----- design/fpcvt_pkg.sv -----
package fpcvt_pkg;

   localparam logic KIND_WIDEN  = 1'b0;
   localparam logic KIND_NARROW = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [63:0] value_low;
      logic [63:0] value_high;
   } req_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
   } rsp_type;

   // per-stage control between pipeline stages
   typedef struct packed {
      logic valid;
      logic kind;
   } stage_ctl_type;

endpackage

// ----- design/fp64_fp128_format_converter.sv -----
// path: stage 1, stage 2, then stage 3, the output register, which drives the response
// throughput: one transaction per cycle when not stalled; three register stages
// a stall holds every occupied stage in place while empty stages still fill; nothing is lost or repeated
// reset: synchronous, clears all stage valid bits; payload registers are not reset
module fp64_fp128_format_converter
   import fpcvt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
`include "assert_macros.svh"

   // stage 1 registers: decoded operand
   stage_ctl_type s1_ff, s1_in;
   logic        s1_sign_ff;
   logic [14:0] s1_exp_ff;      // 11-bit or 15-bit exponent
   logic [51:0] s1_frac_ff;
   logic [59:0] s1_rem_ff;
   logic [5:0]  s1_pos_ff;
   // stage 2 registers: assembled result before rounding
   stage_ctl_type s2_ff;
   logic [63:0] s2_hi_ff, s2_lo_ff;
   logic        s2_round_ff;    // narrow: add one
   // stage 3 = output register
   logic        s3_valid_ff;
   rsp_type     s3_ff;

   logic adv3, adv2, adv1;
   assign adv3 = !s3_valid_ff || rsp_ready;
   assign adv2 = !s2_ff.valid || adv3;
   assign adv1 = !s1_ff.valid || adv2;
   assign req_ready = adv1;

   // stage 0 to 1 decode
   logic [5:0] pos_w;
   fpcvt_lzc52 u_lzc (.frac(req_data.value_low[51:0]), .pos(pos_w));

   always_comb begin
      s1_in.valid = req_valid;
      s1_in.kind  = req_data.kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else if (adv1) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         if (req_data.kind == KIND_WIDEN) begin
            s1_sign_ff <= req_data.value_low[63];
            s1_exp_ff  <= {4'd0, req_data.value_low[62:52]};
            s1_frac_ff <= req_data.value_low[51:0];
            s1_rem_ff  <= '0;
         end else begin
            s1_sign_ff <= req_data.value_high[63];
            s1_exp_ff  <= req_data.value_high[62:48];
            s1_frac_ff <= {req_data.value_high[47:0], req_data.value_low[63:60]};
            s1_rem_ff  <= req_data.value_low[59:0];
         end
         s1_pos_ff <= pos_w;
      end
   end

   // stage 1 to 2: exponent mapping, normalize or denormalize shift
   logic [63:0] hi_c, lo_c;
   logic        rnd_c;
   logic [51:0] wf;
   logic [14:0] be;
   logic signed [16:0] de;
   logic [5:0]  sh;
   logic [52:0] sig, kept;
   logic        rbit, sticky;
   logic [52:0] lowmask;

   always_comb begin
      hi_c = '0;
      lo_c = '0;
      rnd_c = 1'b0;
      wf = s1_frac_ff;
      be = '0;
      de = 17'(s1_exp_ff) - 17'sd15360;
      sh = '0;
      sig = {1'b1, s1_frac_ff};
      kept = '0;
      rbit = 1'b0;
      sticky = 1'b0;
      lowmask = '0;
      if (s1_ff.kind == KIND_WIDEN) begin
         if (s1_exp_ff[10:0] == 11'h7FF) begin
            be = 15'h7FFF;
            if (s1_frac_ff != '0) wf[51] = 1'b1;
         end else if (s1_exp_ff[10:0] == '0) begin
            if (s1_frac_ff != '0) begin
               wf = 52'(s1_frac_ff << (6'd52 - s1_pos_ff));
               be = 15'(s1_pos_ff) + 15'd15309;
            end
         end else begin
            be = s1_exp_ff + 15'd15360;
         end
         hi_c = {s1_sign_ff, be, wf[51:4]};
         lo_c = {wf[3:0], 60'd0};
      end else begin
         if (s1_exp_ff == 15'h7FFF) begin
            if (s1_frac_ff == '0 && s1_rem_ff == '0)
               lo_c = {s1_sign_ff, 11'h7FF, 52'd0};
            else
               lo_c = {s1_sign_ff, 11'h7FF, 1'b1, s1_frac_ff[50:0]};
         end else if (s1_exp_ff == '0) begin
            lo_c = {s1_sign_ff, 63'd0};
         end else if (de >= 17'sd2047) begin
            lo_c = {s1_sign_ff, 11'h7FF, 52'd0};
         end else if (de >= 17'sd1) begin
            lo_c = {s1_sign_ff, de[10:0], s1_frac_ff};
            rnd_c = s1_rem_ff[59] && ((s1_rem_ff[58:0] != '0) || s1_frac_ff[0]);
         end else if (de <= -17'sd53) begin
            lo_c = {s1_sign_ff, 63'd0};
         end else begin
            sh = 6'(17'sd1 - de);
            kept = sig >> sh;
            rbit = sig[sh - 6'd1];
            lowmask = (53'd1 << (sh - 6'd1)) - 53'd1;
            sticky = ((sig & lowmask) != '0) || (s1_rem_ff != '0);
            lo_c = {s1_sign_ff, 10'd0, kept};
            rnd_c = rbit && (sticky || kept[0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else if (adv2) begin
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_hi_ff    <= hi_c;
         s2_lo_ff    <= lo_c;
         s2_round_ff <= rnd_c;
      end
   end

   // stage 2 to 3: narrowing adds the rounding increment, carry runs into exponent; widening passes through
   rsp_type s3_in;
   always_comb begin
      if (s2_ff.kind == KIND_WIDEN) begin
         s3_in.result_low  = s2_lo_ff;
         s3_in.result_high = s2_hi_ff;
      end else begin
         s3_in.result_low  = {s2_lo_ff[63], s2_lo_ff[62:0] + {62'd0, s2_round_ff}};
         s3_in.result_high = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv3) begin
         s3_valid_ff <= s2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_ff <= s3_in;
      end
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_data  = s3_ff;

   // narrowing never drives the high word
   `ASSERT_IMPL(a_narrow_high_zero, clock, reset,
      s2_ff.valid && s2_ff.kind == KIND_NARROW && adv3, s3_in.result_high == '0)
   // stalled output holds its transaction
   `ASSERT_NEXT(a_stall_holds, clock, reset,
      s3_valid_ff && !rsp_ready, s3_valid_ff && $stable(s3_ff))
   // no acceptance while the whole pipe is blocked
   `ASSERT_IMPL(a_ready_tracks, clock, reset,
      s1_ff.valid && s2_ff.valid && s3_valid_ff && !rsp_ready, !req_ready)
endmodule

// ----- design/fpcvt_lzc52.sv -----
// leading-one position of a 52-bit fraction, combinational
module fpcvt_lzc52
   import fpcvt_pkg::*;
(
   input  logic [51:0] frac,
   output logic [5:0]  pos
);
   logic [12:0] grp_any;
   logic [1:0]  grp_pos [13];
   logic [3:0]  top_grp;

   // per nibble leading one
   always_comb begin
      for (int g = 0; g < 13; g++) begin
         grp_any[g] = |frac[g*4 +: 4];
         if (frac[g*4+3])      grp_pos[g] = 2'd3;
         else if (frac[g*4+2]) grp_pos[g] = 2'd2;
         else if (frac[g*4+1]) grp_pos[g] = 2'd1;
         else                  grp_pos[g] = 2'd0;
      end
   end

   // highest nonzero nibble
   always_comb begin
      top_grp = 4'd0;
      for (int g = 0; g < 13; g++) begin
         if (grp_any[g]) top_grp = 4'(g);
      end
      pos = {top_grp, 2'b00} + {4'd0, grp_pos[top_grp]};
   end
endmodule
